FILE: rtl/nnd_pkg.sv
`default_nettype none
package nnd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_SIDE  = 2048;

  localparam int CFG_W   = 12;
  localparam int SIDE_W  = $clog2(MAX_SIDE) + 1;
  localparam int CNT_W   = $clog2(MAX_SIDE);
  localparam int IDX_W   = SIDE_W;
  localparam int ACC_W   = SIDE_W + FRAC_BITS;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;
  localparam int WR_INDEX_W = 8;
  localparam int DIV_STEPS  = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [WR_INDEX_W-1:0] REG_SOURCE_WIDTH  = WR_INDEX_W'(0);
  localparam logic [WR_INDEX_W-1:0] REG_SOURCE_HEIGHT = WR_INDEX_W'(1);
  localparam logic [WR_INDEX_W-1:0] REG_TARGET_WIDTH  = WR_INDEX_W'(2);
  localparam logic [WR_INDEX_W-1:0] REG_TARGET_HEIGHT = WR_INDEX_W'(3);

  localparam int RST_SOURCE_WIDTH  = 324;
  localparam int RST_SOURCE_HEIGHT = 244;
  localparam int RST_TARGET_WIDTH  = 81;
  localparam int RST_TARGET_HEIGHT = 61;

  localparam logic [ACC_W-1:0] RST_COL_RATIO =
    ACC_W'(((RST_SOURCE_WIDTH << FRAC_BITS) / RST_TARGET_WIDTH) + 1);
  localparam logic [ACC_W-1:0] RST_ROW_RATIO =
    ACC_W'(((RST_SOURCE_HEIGHT << FRAC_BITS) / RST_TARGET_HEIGHT) + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [SIDE_W-1:0] sw;
    logic [SIDE_W-1:0] sh;
    logic [SIDE_W-1:0] tw;
    logic [SIDE_W-1:0] th;
    logic [ACC_W-1:0]  col_ratio;
    logic [ACC_W-1:0]  row_ratio;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } res_t;

  function automatic logic [SIDE_W-1:0] eff_source(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] eff_target(input logic [CFG_W-1:0] t,
                                                    input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (t == '0) begin
      r = SIDE_W'(1);
    end else if (32'(t) > 32'(s)) begin
      r = s;
    end else begin
      r = SIDE_W'(t);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nnd_in_if.sv
`default_nettype none
interface nnd_in_if;
  import nnd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;

  modport source(output valid, output pixel_in, output frame_start, input ready);
  modport sink(input valid, input pixel_in, input frame_start, output ready);
endinterface
`default_nettype wire

FILE: rtl/nnd_out_if.sv
`default_nettype none
interface nnd_out_if;
  import nnd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               frame_last;

  modport source(output valid, output pixel_out, output out_col, output out_row,
                 output frame_last, input ready);
  modport sink(input valid, input pixel_out, input out_col, input out_row,
               input frame_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/nnd_div.sv
`default_nettype none
module nnd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [nnd_pkg::SIDE_W-1:0]  source_size,
  input  wire logic [nnd_pkg::SIDE_W-1:0]  target_size,
  input  wire logic [nnd_pkg::ACC_W-1:0]   reset_ratio,
  output logic                             busy,
  output logic [nnd_pkg::ACC_W-1:0]        ratio
);
  import nnd_pkg::*;

  logic [DIV_CNT_W-1:0] count;
  logic [SIDE_W-1:0]    divisor;
  logic [SIDE_W-1:0]    rem;
  logic [ACC_W-1:0]     shreg;
  logic [SIDE_W:0]      trial;
  logic                 qbit;
  logic [SIDE_W-1:0]    rem_next;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of shreg while quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem, shreg[ACC_W-1]};
    qbit  = trial >= {1'b0, divisor};
    if (qbit) begin
      rem_next = SIDE_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = SIDE_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      ratio <= reset_ratio;
    end else if (start) begin
      busy    <= 1'b1;
      count   <= '0;
      divisor <= target_size;
      rem     <= '0;
      shreg   <= {source_size, {FRAC_BITS{1'b0}}};
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[ACC_W-2:0], qbit};
      count <= count + DIV_CNT_W'(1);
      if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy  <= 1'b0;
        ratio <= {shreg[ACC_W-2:0], qbit} + ACC_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/nnd_ratio.sv
`default_nettype none
module nnd_ratio (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [nnd_pkg::WR_INDEX_W-1:0]  wr_index,
  input  wire logic [nnd_pkg::CFG_W-1:0]       wr_data,
  output nnd_pkg::geom_t                       geom,
  output logic                                 busy,
  output logic                                 clear
);
  import nnd_pkg::*;

  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic [CFG_W-1:0] target_width;
  logic [CFG_W-1:0] target_height;
  logic             pending;
  logic             col_busy;
  logic             row_busy;
  logic             index_ok;
  logic [ACC_W-1:0] col_ratio;
  logic [ACC_W-1:0] row_ratio;

  always_comb begin
    unique case (wr_index)
      REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
      REG_TARGET_WIDTH, REG_TARGET_HEIGHT: index_ok = 1'b1;
      default:                             index_ok = 1'b0;
    endcase
  end

  assign clear = wr_en && index_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= CFG_W'(RST_SOURCE_WIDTH);
      source_height <= CFG_W'(RST_SOURCE_HEIGHT);
      target_width  <= CFG_W'(RST_TARGET_WIDTH);
      target_height <= CFG_W'(RST_TARGET_HEIGHT);
      pending       <= 1'b0;
    end else begin
      pending <= clear;
      if (wr_en) begin
        unique case (wr_index)
          REG_SOURCE_WIDTH:  source_width  <= wr_data;
          REG_SOURCE_HEIGHT: source_height <= wr_data;
          REG_TARGET_WIDTH:  target_width  <= wr_data;
          REG_TARGET_HEIGHT: target_height <= wr_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    geom.sw        = eff_source(source_width);
    geom.sh        = eff_source(source_height);
    geom.tw        = eff_target(target_width, geom.sw);
    geom.th        = eff_target(target_height, geom.sh);
    geom.col_ratio = col_ratio;
    geom.row_ratio = row_ratio;
  end

  // The divisions start the cycle after a write, once the register holds it.
  nnd_div u_col_div (
    .clk         (clk),
    .rst         (rst),
    .start       (pending),
    .source_size (geom.sw),
    .target_size (geom.tw),
    .reset_ratio (RST_COL_RATIO),
    .busy        (col_busy),
    .ratio       (col_ratio)
  );

  nnd_div u_row_div (
    .clk         (clk),
    .rst         (rst),
    .start       (pending),
    .source_size (geom.sh),
    .target_size (geom.th),
    .reset_ratio (RST_ROW_RATIO),
    .busy        (row_busy),
    .ratio       (row_ratio)
  );

  assign busy = pending || col_busy || row_busy;
endmodule
`default_nettype wire

FILE: rtl/nnd_front.sv
`default_nettype none
module nnd_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      clear,
  input  wire nnd_pkg::geom_t            geom,
  input  wire logic                      accept,
  input  wire logic [nnd_pkg::PIX_W-1:0] pixel_in,
  input  wire logic                      frame_start,
  output logic                           push,
  output nnd_pkg::res_t                  result
);
  import nnd_pkg::*;

  logic [CNT_W-1:0] src_col;
  logic [CNT_W-1:0] src_row;
  logic [IDX_W-1:0] dst_col;
  logic [IDX_W-1:0] dst_row;
  logic [ACC_W-1:0] col_acc;
  logic [ACC_W-1:0] row_acc;

  logic [CNT_W-1:0] cur_src_col;
  logic [CNT_W-1:0] cur_src_row;
  logic [IDX_W-1:0] cur_dst_col;
  logic [IDX_W-1:0] cur_dst_row;
  logic [ACC_W-1:0] cur_col_acc;
  logic [ACC_W-1:0] cur_row_acc;

  logic [CNT_W-1:0] src_col_next;
  logic [CNT_W-1:0] src_row_next;
  logic [IDX_W-1:0] dst_col_next;
  logic [IDX_W-1:0] dst_row_next;
  logic [ACC_W-1:0] col_acc_next;
  logic [ACC_W-1:0] row_acc_next;

  logic col_hit;
  logic row_hit;

  always_comb begin
    // A frame start restarts the position before the pixel is judged.
    if (frame_start) begin
      cur_src_col = '0;
      cur_src_row = '0;
      cur_dst_col = '0;
      cur_dst_row = '0;
      cur_col_acc = '0;
      cur_row_acc = '0;
    end else begin
      cur_src_col = src_col;
      cur_src_row = src_row;
      cur_dst_col = dst_col;
      cur_dst_row = dst_row;
      cur_col_acc = col_acc;
      cur_row_acc = row_acc;
    end

    col_hit = (cur_dst_col < geom.tw) &&
              (cur_col_acc[ACC_W-1:FRAC_BITS] == {1'b0, cur_src_col});
    row_hit = (cur_dst_row < geom.th) &&
              (cur_row_acc[ACC_W-1:FRAC_BITS] == {1'b0, cur_src_row});

    push          = accept && col_hit && row_hit;
    result.pixel  = pixel_in;
    result.col    = cur_dst_col[COORD_W-1:0];
    result.row    = cur_dst_row[COORD_W-1:0];
    result.last   = (cur_dst_col + IDX_W'(1) == geom.tw) &&
                    (cur_dst_row + IDX_W'(1) == geom.th);

    src_col_next = cur_src_col;
    src_row_next = cur_src_row;
    dst_col_next = cur_dst_col;
    dst_row_next = cur_dst_row;
    col_acc_next = cur_col_acc;
    row_acc_next = cur_row_acc;

    if (col_hit) begin
      dst_col_next = cur_dst_col + IDX_W'(1);
      col_acc_next = cur_col_acc + geom.col_ratio;
    end
    if ({1'b0, cur_src_col} + SIDE_W'(1) >= geom.sw) begin
      src_col_next = '0;
      dst_col_next = '0;
      col_acc_next = '0;
      if (row_hit) begin
        dst_row_next = cur_dst_row + IDX_W'(1);
        row_acc_next = cur_row_acc + geom.row_ratio;
      end
      if ({1'b0, cur_src_row} + SIDE_W'(1) >= geom.sh) begin
        // Last pixel of the source frame: wrap to a new frame.
        src_row_next = '0;
        dst_row_next = '0;
        row_acc_next = '0;
      end else begin
        src_row_next = cur_src_row + CNT_W'(1);
      end
    end else begin
      src_col_next = cur_src_col + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      src_col <= '0;
      src_row <= '0;
      dst_col <= '0;
      dst_row <= '0;
      col_acc <= '0;
      row_acc <= '0;
    end else if (accept) begin
      src_col <= src_col_next;
      src_row <= src_row_next;
      dst_col <= dst_col_next;
      dst_row <= dst_row_next;
      col_acc <= col_acc_next;
      row_acc <= row_acc_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/nnd_queue.sv
`default_nettype none
module nnd_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire nnd_pkg::res_t push_data,
  output logic         full,
  output logic         valid,
  input  wire logic    pop,
  output nnd_pkg::res_t head
);
  import nnd_pkg::*;

  res_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full   = count == QCNT_W'(QDEPTH);
  assign valid  = count != '0;
  assign head   = entries[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/nearest_neighbor_downscaler.sv
`default_nettype none
// A selected pixel is written into the result queue as its request is accepted and leaves from the queue head.
// Throughput: one source pixel per cycle while the queue is not full and no register write is in progress;
// a four-entry result queue decouples the sides. After a register write the input is held off while the two
// bit-serial dividers form the new step ratios, one quotient bit per cycle.
// Reset (synchronous, active high) restores the default sizes and their ratios at once.
module nearest_neighbor_downscaler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [nnd_pkg::WR_INDEX_W-1:0]  wr_index,
  input  wire logic [nnd_pkg::CFG_W-1:0]       wr_data,
  nnd_in_if.sink                               in_stream,
  nnd_out_if.source                            out_stream
);
  import nnd_pkg::*;

  geom_t geom;
  logic  busy;
  logic  clear;
  logic  accept;
  logic  push;
  logic  full;
  res_t  result;
  res_t  head;

  nnd_ratio u_ratio (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .geom     (geom),
    .busy     (busy),
    .clear    (clear)
  );

  assign in_stream.ready = !busy && !full;
  assign accept          = in_stream.valid && in_stream.ready;

  nnd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .geom        (geom),
    .accept      (accept),
    .pixel_in    (in_stream.pixel_in),
    .frame_start (in_stream.frame_start),
    .push        (push),
    .result      (result)
  );

  nnd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (full),
    .valid     (out_stream.valid),
    .pop       (out_stream.ready),
    .head      (head)
  );

  assign out_stream.pixel_out  = head.pixel;
  assign out_stream.out_col    = head.col;
  assign out_stream.out_row    = head.row;
  assign out_stream.frame_last = head.last;
endmodule
`default_nettype wire

FILE: tb/nnd_pick_checker.sv
`timescale 1ns / 100ps
module nnd_pick_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [nnd_pkg::WR_INDEX_W-1:0] wr_index,
  input  logic [nnd_pkg::CFG_W-1:0]      wr_data,
  nnd_in_if                              in_mon,
  nnd_out_if                             out_mon,
  output int                             mismatches,
  output int                             waiting
);
  import nnd_pkg::*;

  logic [CFG_W-1:0]  cfg_src_w;
  logic [CFG_W-1:0]  cfg_src_h;
  logic [CFG_W-1:0]  cfg_dst_w;
  logic [CFG_W-1:0]  cfg_dst_h;

  logic [CNT_W-1:0]  col_cnt;
  logic [CNT_W-1:0]  row_cnt;
  logic [IDX_W-1:0]  dst_col;
  logic [IDX_W-1:0]  dst_row;
  logic [ACC_W-1:0]  col_acc;
  logic [ACC_W-1:0]  row_acc;
  logic [ACC_W-1:0]  col_step;
  logic [ACC_W-1:0]  row_step;

  res_t picked_q[$];

  initial begin
    mismatches = 0;
    waiting = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [SIDE_W-1:0] src_side(input logic [CFG_W-1:0] v);
    if (v == '0) return SIDE_W'(1);
    if (SIDE_W'(v) > SIDE_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return SIDE_W'(v);
  endfunction

  // A zero target counts as one, and a target above the source is pulled down to it.
  function automatic logic [SIDE_W-1:0] dst_side(input logic [CFG_W-1:0] t,
                                                 input logic [SIDE_W-1:0] s);
    if (t == '0) return SIDE_W'(1);
    if (SIDE_W'(t) > s) return s;
    return SIDE_W'(t);
  endfunction

  task automatic clear_position();
    col_cnt = '0;
    row_cnt = '0;
    dst_col = '0;
    dst_row = '0;
    col_acc = '0;
    row_acc = '0;
  endtask

  task automatic recompute_steps();
    logic [SIDE_W-1:0] sw, sh, tw, th;
    sw = src_side(cfg_src_w);
    sh = src_side(cfg_src_h);
    tw = dst_side(cfg_dst_w, sw);
    th = dst_side(cfg_dst_h, sh);
    col_step = ACC_W'(((64'(sw) << FRAC_BITS) / 64'(tw)) + 64'd1);
    row_step = ACC_W'(((64'(sh) << FRAC_BITS) / 64'(th)) + 64'd1);
  endtask

  task automatic write_register(input logic [WR_INDEX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    case (idx)
      REG_SOURCE_WIDTH: cfg_src_w = val;
      REG_SOURCE_HEIGHT: cfg_src_h = val;
      REG_TARGET_WIDTH: cfg_dst_w = val;
      REG_TARGET_HEIGHT: cfg_dst_h = val;
      default: return;
    endcase
    recompute_steps();
    clear_position();
  endtask

  // Judges one source pixel and queues the destination pixel it becomes, if any.
  task automatic pick_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    logic [SIDE_W-1:0] sw, sh, tw, th;
    logic col_hit, row_hit;
    res_t r;
    sw = src_side(cfg_src_w);
    sh = src_side(cfg_src_h);
    tw = dst_side(cfg_dst_w, sw);
    th = dst_side(cfg_dst_h, sh);
    if (fs) clear_position();
    col_hit = (dst_col < tw) && ((col_acc >> FRAC_BITS) == ACC_W'(col_cnt));
    row_hit = (dst_row < th) && ((row_acc >> FRAC_BITS) == ACC_W'(row_cnt));
    if (col_hit && row_hit) begin
      r.pixel = pix;
      r.col = dst_col[COORD_W-1:0];
      r.row = dst_row[COORD_W-1:0];
      r.last = (32'(dst_col) + 1 == 32'(tw)) && (32'(dst_row) + 1 == 32'(th));
      picked_q.push_back(r);
    end
    if (col_hit) begin
      dst_col = dst_col + 1'b1;
      col_acc = col_acc + col_step;
    end
    if (32'(col_cnt) + 1 >= 32'(sw)) begin
      col_cnt = '0;
      dst_col = '0;
      col_acc = '0;
      if (row_hit) begin
        dst_row = dst_row + 1'b1;
        row_acc = row_acc + row_step;
      end
      if (32'(row_cnt) + 1 >= 32'(sh)) begin
        clear_position();
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cfg_src_w = CFG_W'(RST_SOURCE_WIDTH);
      cfg_src_h = CFG_W'(RST_SOURCE_HEIGHT);
      cfg_dst_w = CFG_W'(RST_TARGET_WIDTH);
      cfg_dst_h = CFG_W'(RST_TARGET_HEIGHT);
      recompute_steps();
      clear_position();
      picked_q.delete();
    end else begin
      if (wr_en) write_register(wr_index, wr_data);
      if (in_mon.valid && in_mon.ready) pick_pixel(in_mon.pixel_in, in_mon.frame_start);
      if (out_mon.valid && out_mon.ready) begin
        if (picked_q.size() == 0) begin
          report_mismatch("result arrived with no pixel pending");
        end else begin
          want = picked_q.pop_front();
          if (out_mon.pixel_out !== want.pixel)
            report_mismatch($sformatf("pixel_out: got %0d, want %0d",
                                      out_mon.pixel_out, want.pixel));
          if (out_mon.out_col !== want.col)
            report_mismatch($sformatf("out_col: got %0d, want %0d",
                                      out_mon.out_col, want.col));
          if (out_mon.out_row !== want.row)
            report_mismatch($sformatf("out_row: got %0d, want %0d",
                                      out_mon.out_row, want.row));
          if (out_mon.frame_last !== want.last)
            report_mismatch($sformatf("frame_last: got %0b, want %0b",
                                      out_mon.frame_last, want.last));
        end
      end
    end
    waiting = picked_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import nnd_pkg::*;

  localparam logic [WR_INDEX_W-1:0] REG_PAST_LAST = WR_INDEX_W'(4);
  localparam logic [WR_INDEX_W-1:0] REG_INDEX_MAX = '1;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [WR_INDEX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  int mismatches;
  int waiting;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  bit hold_request = 1'b0;

  nnd_in_if in_bus();
  nnd_out_if out_bus();

  nearest_neighbor_downscaler i_dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_stream(in_bus),
    .out_stream(out_bus)
  );

  nnd_pick_checker i_check (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_mon(in_bus),
    .out_mon(out_bus),
    .mismatches(mismatches),
    .waiting(waiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_bus.ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.pixel_in <= pix;
    in_bus.frame_start <= fs;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops the request stream and waits until every picked pixel has come out.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [WR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
  endtask

  task automatic program_geometry(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                                  input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    wr_en <= 1'b0;
  endtask

  task automatic random_phase();
    logic [CFG_W-1:0] sw, sh, tw, th;
    int frame_px, pos, n;
    bit noisy;
    logic fs;
    case ($urandom_range(9))
      0: sw = '0;
      1: sw = CFG_W'($urandom_range(13, 40));
      default: sw = CFG_W'($urandom_range(1, 12));
    endcase
    sh = ($urandom_range(9) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
    tw = CFG_W'($urandom_range(0, sw + 2));
    th = CFG_W'($urandom_range(0, sh + 2));
    settle();
    if ($urandom_range(4) == 0) begin
      write_reg(WR_INDEX_W'($urandom_range(REG_PAST_LAST, REG_INDEX_MAX)), CFG_W'($urandom));
    end
    program_geometry(sw, sh, tw, th);
    frame_px = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
    noisy = ($urandom_range(9) < 3);
    n = $urandom_range(20, 80);
    pos = 0;
    repeat (n) begin
      if (noisy) begin
        fs = ($urandom_range(9) == 0);
      end else begin
        // Now and then a frame is cut short by an early frame start.
        if ($urandom_range(39) == 0) pos = 0;
        fs = (pos == 0);
      end
      send_pixel(PIX_W'($urandom), fs);
      pos = fs ? 1 : pos + 1;
      if (pos >= frame_px) pos = 0;
    end
  endtask

  task automatic random_section(input int tx_pct, input int rx_pct, input int count);
    int stop_at;
    stop_at = items_sent + count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (items_sent < stop_at) random_phase();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.pixel_in = '0;
    in_bus.frame_start = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default geometry straight out of reset, with pixel extremes.
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b0);
    repeat (7) send_pixel(PIX_W'($urandom), 1'b0);

    // Writes to indexes past the last register must not disturb the row in progress.
    settle();
    write_reg(REG_PAST_LAST, '0);
    write_reg(REG_INDEX_MAX, '1);
    wr_en <= 1'b0;
    repeat (4) send_pixel(8'hFF, 1'b0);

    // All-zero sizes behave as a one-pixel image.
    settle();
    program_geometry('0, '0, '0, '0);
    send_pixel(8'h12, 1'b0);
    send_pixel(8'h34, 1'b1);
    send_pixel(8'h56, 1'b0);

    // Targets above the source are clamped; the frame wraps with no frame start.
    settle();
    program_geometry(12'd3, 12'd2, 12'd5, 12'd9);
    repeat (7) send_pixel(PIX_W'($urandom), 1'b0);

    // Oversized source width saturates to the largest side, so picks fall every 128 pixels.
    tx_idle_pct = 13;
    rx_idle_pct = 52;
    settle();
    program_geometry('1, 12'd1, 12'd16, '0);
    for (int i = 0; i < 260; i++) send_pixel(PIX_W'($urandom), i == 0);

    // The same saturation down a one-pixel column.
    settle();
    program_geometry(12'd1, '1, 12'd1, 12'd16);
    for (int i = 0; i < 260; i++) send_pixel(PIX_W'($urandom), i == 0);

    // Every pixel is picked while the result side holds off, so the input backs up.
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_geometry(12'd8, 12'd4, 12'd8, 12'd4);
    hold_request = 1'b1;
    for (int i = 0; i < 48; i++) send_pixel(PIX_W'($urandom), i == 0);

    random_section(13, 52, 140);
    random_section(52, 13, 140);
    random_section(0, 0, 140);

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
